@@ rtl/ttsce_pkg.sv @@
`default_nettype none
package ttsce_pkg;

	// screen geometry defaults
	localparam int SCREEN_COLS_DEF = 80;
	localparam int SCREEN_ROWS_DEF = 24;

	// queue between front and back, a power of two
	localparam int QUEUE_DEPTH = 2;

	// byte codes
	localparam logic [7:0] ESC_BYTE     = 8'h1B;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] CSI_BYTE     = 8'h5B;	// '['
	localparam logic [7:0] SEP_BYTE     = 8'h3B;	// ';'
	localparam logic [7:0] SGR_FINAL    = 8'h6D;	// 'm'
	localparam logic [7:0] DIGIT_LO     = 8'h30;	// '0'
	localparam logic [7:0] DIGIT_HI     = 8'h39;	// '9'
	localparam logic [7:0] FINAL_LO     = 8'h40;
	localparam logic [7:0] FINAL_HI     = 8'h7E;

	// SGR codes
	localparam logic [9:0] PARAM_MAX    = 10'd1023;
	localparam logic [9:0] SGR_RESET    = 10'd0;
	localparam logic [9:0] SGR_FG_LO    = 10'd30;
	localparam logic [9:0] SGR_FG_HI    = 10'd37;
	localparam logic [9:0] SGR_FG_DEF   = 10'd39;
	localparam logic [9:0] SGR_BG_LO    = 10'd40;
	localparam logic [9:0] SGR_BG_HI    = 10'd47;
	localparam logic [9:0] SGR_BG_DEF   = 10'd49;

	typedef logic [2:0] color_t;
	localparam color_t COLOR_WHITE = 3'd7;
	localparam color_t COLOR_BLACK = 3'd0;

	typedef enum logic [1:0] {
		PH_TEXT,
		PH_ESC,
		PH_CSI
	} phase_t;

	typedef enum logic [1:0] {
		PS_NONE,
		PS_DIGITS,
		PS_BAD
	} pstate_t;

	typedef enum logic {
		OP_DRAW,
		OP_COLOR
	} op_kind_t;

	// one request handed from front to back
	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] glyph;
		color_t     fg;
		color_t     bg;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} push_t;

endpackage
`default_nettype wire

@@ rtl/ttsce_front.sv @@
`default_nettype none
module ttsce_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_valid,
	input  wire logic [7:0]    byte_in,
	output logic               byte_stall,
	input  wire logic          q_full,
	output ttsce_pkg::push_t   push
);

	typedef struct packed {
		ttsce_pkg::color_t fg;
		ttsce_pkg::color_t bg;
	} pair_t;

	ttsce_pkg::phase_t  phase_q, phase_d;
	ttsce_pkg::pstate_t pst_q, pst_d;
	logic [9:0]         pval_q, pval_d;
	ttsce_pkg::color_t  pfg_q, pfg_d, pbg_q, pbg_d;
	ttsce_pkg::color_t  fg_q, fg_d, bg_q, bg_d;
	logic               accept;
	logic [13:0]        pval_x10;
	pair_t              applied;

	// fold the current code into the pending colors
	function automatic pair_t apply_code(ttsce_pkg::pstate_t ps, logic [9:0] val,
			ttsce_pkg::color_t pf, ttsce_pkg::color_t pb);
		pair_t      r;
		logic [9:0] code;
		logic [9:0] off;
		r.fg = pf;
		r.bg = pb;
		code = (ps == ttsce_pkg::PS_NONE) ? ttsce_pkg::SGR_RESET : val;
		off  = '0;
		if (ps != ttsce_pkg::PS_BAD) begin
			if (code == ttsce_pkg::SGR_RESET) begin
				r.fg = ttsce_pkg::COLOR_WHITE;
				r.bg = ttsce_pkg::COLOR_BLACK;
			end else if (code inside {[ttsce_pkg::SGR_FG_LO:ttsce_pkg::SGR_FG_HI]}) begin
				off  = code - ttsce_pkg::SGR_FG_LO;
				r.fg = off[2:0];
			end else if (code == ttsce_pkg::SGR_FG_DEF) begin
				r.fg = ttsce_pkg::COLOR_WHITE;
			end else if (code inside {[ttsce_pkg::SGR_BG_LO:ttsce_pkg::SGR_BG_HI]}) begin
				off  = code - ttsce_pkg::SGR_BG_LO;
				r.bg = off[2:0];
			end else if (code == ttsce_pkg::SGR_BG_DEF) begin
				r.bg = ttsce_pkg::COLOR_BLACK;
			end
		end
		return r;
	endfunction

	assign byte_stall = q_full;
	assign accept     = byte_valid && !byte_stall;
	assign pval_x10   = {1'b0, pval_q, 3'b000} + {3'b000, pval_q, 1'b0} +
		{10'd0, byte_in[3:0]};
	assign applied    = apply_code(pst_q, pval_q, pfg_q, pbg_q);

	// classify the byte and advance the escape parser
	always_comb begin
		phase_d      = phase_q;
		pst_d        = pst_q;
		pval_d       = pval_q;
		pfg_d        = pfg_q;
		pbg_d        = pbg_q;
		fg_d         = fg_q;
		bg_d         = bg_q;
		push.valid   = 1'b0;
		push.op.kind  = ttsce_pkg::OP_DRAW;
		push.op.glyph = byte_in;
		push.op.fg    = fg_q;
		push.op.bg    = bg_q;
		if (accept) begin
			if (byte_in == ttsce_pkg::ESC_BYTE) begin
				phase_d = ttsce_pkg::PH_ESC;
				pst_d   = ttsce_pkg::PS_NONE;
				pval_d  = '0;
				pfg_d   = fg_q;
				pbg_d   = bg_q;
			end else begin
				case (phase_q)
					ttsce_pkg::PH_ESC: begin
						phase_d = (byte_in == ttsce_pkg::CSI_BYTE) ?
							ttsce_pkg::PH_CSI : ttsce_pkg::PH_TEXT;
					end
					ttsce_pkg::PH_CSI: begin
						if (byte_in inside {[ttsce_pkg::DIGIT_LO:ttsce_pkg::DIGIT_HI]}) begin
							if (pst_q != ttsce_pkg::PS_BAD) begin
								pval_d = (pval_x10 > {4'd0, ttsce_pkg::PARAM_MAX}) ?
									ttsce_pkg::PARAM_MAX : pval_x10[9:0];
								pst_d  = ttsce_pkg::PS_DIGITS;
							end
						end else if (byte_in == ttsce_pkg::SEP_BYTE) begin
							pfg_d  = applied.fg;
							pbg_d  = applied.bg;
							pval_d = '0;
							pst_d  = ttsce_pkg::PS_NONE;
						end else if (byte_in == ttsce_pkg::SGR_FINAL) begin
							pfg_d   = applied.fg;
							pbg_d   = applied.bg;
							fg_d    = applied.fg;
							bg_d    = applied.bg;
							phase_d = ttsce_pkg::PH_TEXT;
							push.valid   = 1'b1;
							push.op.kind = ttsce_pkg::OP_COLOR;
							push.op.fg   = applied.fg;
							push.op.bg   = applied.bg;
						end else if (byte_in inside
								{[ttsce_pkg::FINAL_LO:ttsce_pkg::FINAL_HI]}) begin
							phase_d = ttsce_pkg::PH_TEXT;
						end else begin
							pst_d = ttsce_pkg::PS_BAD;
						end
					end
					default: begin
						push.valid = 1'b1;
					end
				endcase
			end
		end
	end

	// hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ttsce_pkg::PH_TEXT;
			pst_q   <= ttsce_pkg::PS_NONE;
			pval_q  <= '0;
			pfg_q   <= ttsce_pkg::COLOR_WHITE;
			pbg_q   <= ttsce_pkg::COLOR_BLACK;
			fg_q    <= ttsce_pkg::COLOR_WHITE;
			bg_q    <= ttsce_pkg::COLOR_BLACK;
		end else begin
			phase_q <= phase_d;
			pst_q   <= pst_d;
			pval_q  <= pval_d;
			pfg_q   <= pfg_d;
			pbg_q   <= pbg_d;
			fg_q    <= fg_d;
			bg_q    <= bg_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ttsce_queue.sv @@
`default_nettype none
module ttsce_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ttsce_pkg::push_t push,
	output logic             full,
	output logic             not_empty,
	output ttsce_pkg::op_t   head,
	input  wire logic        pop
);

	localparam int QD  = ttsce_pkg::QUEUE_DEPTH;
	localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

	ttsce_pkg::op_t   mem_q [QD];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QAW:0]     count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == (QAW+1)'(QD));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rptr_q];
	assign do_push   = push.valid && !full;
	assign do_pop    = pop && not_empty;

	// store requests
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push.op;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/ttsce_back.sv @@
`default_nettype none
module ttsce_back #(
	parameter int SCREEN_COLS = ttsce_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = ttsce_pkg::SCREEN_ROWS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire ttsce_pkg::op_t q_op,
	output logic                q_pop,
	output logic                cell_valid,
	input  wire logic           cell_stall,
	output logic [4:0]          cell_row,
	output logic [6:0]          cell_col,
	output logic [7:0]          glyph_code,
	output logic [2:0]          fg_color,
	output logic [2:0]          bg_color,
	output logic                scroll_up
);

	localparam int COL_W = $clog2(SCREEN_COLS);
	localparam int ROW_W = $clog2(SCREEN_ROWS);

	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	ttsce_pkg::color_t fg_q, bg_q;
	logic              ovalid_q;
	logic [COL_W:0]    col_inc;
	logic [ROW_W:0]    row_inc;
	logic              wrap, scroll;
	logic              out_free, draw;
	logic [COL_W+6:0]  col_ext;
	logic [ROW_W+4:0]  row_ext;

	assign out_free = !ovalid_q || !cell_stall;
	assign q_pop    = q_valid && ((q_op.kind == ttsce_pkg::OP_COLOR) || out_free);
	assign draw     = q_pop && (q_op.kind == ttsce_pkg::OP_DRAW);
	assign col_ext  = {7'd0, col_q};
	assign row_ext  = {5'd0, row_q};
	assign cell_valid = ovalid_q;

	// step the cursor for a drawn cell
	always_comb begin
		col_inc = {1'b0, col_q} + (COL_W+1)'(1);
		row_inc = {1'b0, row_q} + (ROW_W+1)'(1);
		wrap    = (q_op.glyph == ttsce_pkg::NEWLINE_BYTE) ||
			(col_inc >= (COL_W+1)'(SCREEN_COLS));
		scroll  = 1'b0;
		col_d   = col_inc[COL_W-1:0];
		row_d   = row_q;
		if (wrap) begin
			col_d = '0;
			if (row_inc >= (ROW_W+1)'(SCREEN_ROWS)) begin
				row_d  = ROW_W'(SCREEN_ROWS - 1);
				scroll = 1'b1;
			end else begin
				row_d = row_inc[ROW_W-1:0];
			end
		end
	end

	// hold cursor, colors and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			fg_q     <= ttsce_pkg::COLOR_WHITE;
			bg_q     <= ttsce_pkg::COLOR_BLACK;
			ovalid_q <= 1'b0;
		end else begin
			if (q_pop && (q_op.kind == ttsce_pkg::OP_COLOR)) begin
				fg_q <= q_op.fg;
				bg_q <= q_op.bg;
			end
			if (draw) begin
				col_q    <= col_d;
				row_q    <= row_d;
				ovalid_q <= 1'b1;
			end else if (!cell_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (draw) begin
			cell_row   <= row_ext[4:0];
			cell_col   <= col_ext[6:0];
			glyph_code <= q_op.glyph;
			fg_color   <= fg_q;
			bg_color   <= bg_q;
			scroll_up  <= scroll;
		end
	end

endmodule
`default_nettype wire

@@ rtl/text_terminal_sgr_cursor_engine.sv @@
// Terminal byte stream to character-cell writes, with SGR color handling.
// Input channel: byte_in with byte_valid/byte_stall; one terminal output byte
// per request. Output channel: one cell write per drawn byte (row, column,
// glyph, colors, scroll flag) with cell_valid/cell_stall.
// ESC [ ... m sequences change colors for later cells; ESC, sequence bytes
// and the final byte produce no cell write. Newline is drawn, then wraps.
// A drawn byte is written into the request queue when accepted, then popped
// by the back unit into the registered cell output; cell_stall can hold it
// in the queue or in the output register.
// Throughput: one byte per cycle, sustained while the output is taken.
// The front parser and the back cursor unit are split by a two-entry request
// queue; byte_stall rises only when that queue is full, which happens when
// the output register stays stalled.
// Reset: cursor at row 0, column 0, white on black, parser in text mode,
// queue empty and no output valid. When cell_stall is high the output holds
// its values, the queue fills, and then byte_stall rises.
`default_nettype none
module text_terminal_sgr_cursor_engine #(
	parameter int SCREEN_COLS = ttsce_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = ttsce_pkg::SCREEN_ROWS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] byte_in,
	output logic            cell_valid,
	input  wire logic       cell_stall,
	output logic [4:0]      cell_row,
	output logic [6:0]      cell_col,
	output logic [7:0]      glyph_code,
	output logic [2:0]      fg_color,
	output logic [2:0]      bg_color,
	output logic            scroll_up
);

	ttsce_pkg::push_t push;
	ttsce_pkg::op_t   head;
	logic             q_full, q_valid, q_pop;

	ttsce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_in    (byte_in),
		.byte_stall (byte_stall),
		.q_full     (q_full),
		.push       (push)
	);

	ttsce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (head),
		.pop       (q_pop)
	);

	ttsce_back #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_op       (head),
		.q_pop      (q_pop),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.glyph_code (glyph_code),
		.fg_color   (fg_color),
		.bg_color   (bg_color),
		.scroll_up  (scroll_up)
	);

endmodule
`default_nettype wire

@@ rtl/ttsce_checker.sv @@
`default_nettype none
module ttsce_checker #(
	parameter int SCREEN_COLS = ttsce_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = ttsce_pkg::SCREEN_ROWS_DEF
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cell_valid,
	input wire logic       cell_stall,
	input wire logic [4:0] cell_row,
	input wire logic [6:0] cell_col,
	input wire logic [7:0] glyph_code,
	input wire logic       scroll_up
);

	// hold a stalled cell write
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && cell_stall |=> cell_valid && $stable(cell_row) &&
			$stable(cell_col) && $stable(glyph_code) && $stable(scroll_up))
		else $error("stalled cell write changed");

	// keep the cursor on the screen
	a_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid |-> (int'(cell_col) < SCREEN_COLS) && (int'(cell_row) < SCREEN_ROWS))
		else $error("cell write off screen");

	// scroll only from the bottom row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && scroll_up |-> int'(cell_row) == SCREEN_ROWS - 1)
		else $error("scroll from a row other than the last");

	// drop escape bytes
	a_no_esc: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid |-> glyph_code != ttsce_pkg::ESC_BYTE)
		else $error("escape byte drawn");

endmodule

bind text_terminal_sgr_cursor_engine ttsce_checker #(
	.SCREEN_COLS (SCREEN_COLS),
	.SCREEN_ROWS (SCREEN_ROWS)
) u_ttsce_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cell_valid (cell_valid),
	.cell_stall (cell_stall),
	.cell_row   (cell_row),
	.cell_col   (cell_col),
	.glyph_code (glyph_code),
	.scroll_up  (scroll_up)
);
`default_nettype wire
